FILE: rtl/swm2d_pkg.sv
package swm2d_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int EPOCH_BITS     = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_NUM_COLS    = 3'd0,
    CFG_NUM_ROWS    = 3'd1,
    CFG_WINDOW_ROWS = 3'd2,
    CFG_WINDOW_COLS = 3'd3
  } cfg_index_t;

  typedef struct packed {
    logic load;
    logic rd_row_tail;
    logic pop_row_front;
    logic save_rfront;
    logic pop_row_back;
    logic push_row;
    logic load_meta;
    logic rd_col_tail;
    logic pop_col_front;
    logic save_cfront;
    logic pop_col_back;
    logic push_col;
    logic emit;
    logic advance;
  } swm2d_cmd_t;

  typedef struct packed {
    logic sweeping;
    logic rcount_zero;
    logic row_front_exp;
    logic row_back_ge;
    logic do_col;
    logic ccount_zero;
    logic col_front_exp;
    logic col_back_ge;
    logic do_out;
    logic out_free;
  } swm2d_sts_t;

endpackage

FILE: rtl/swm2d_dp.sv
module swm2d_dp #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_WIN_ROWS = 32,
  parameter int MAX_WIN_COLS = 32,
  parameter int PIXEL_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [swm2d_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [swm2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [31:0]                           pixel,
  input  swm2d_pkg::swm2d_cmd_t                 cmd,
  output swm2d_pkg::swm2d_sts_t                 sts,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [31:0]                           window_min,
  output logic [62:0]                           running_sum,
  output logic                                  frame_done
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int NCW = CW + 1;
  localparam int WCW = $clog2(MAX_WIN_COLS + 1);
  localparam int WRW = $clog2(MAX_WIN_ROWS + 1);
  localparam int RIW = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
  localparam int RSW = $clog2(2 * MAX_WIN_COLS) + 1;
  localparam int CIW = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
  localparam int CSW = $clog2(2 * MAX_WIN_ROWS) + 1;
  localparam int XW  = ((CW > WCW) ? CW : WCW) + 1;
  localparam int YW  = ((16 > WRW) ? 16 : WRW) + 1;
  localparam int CAW = $clog2(MAX_COLS * MAX_WIN_ROWS);
  localparam int EB  = swm2d_pkg::EPOCH_BITS;
  localparam int MW  = EB + CIW + WRW;

  // Configuration registers.
  logic [10:0] num_cols_r;
  logic [15:0] num_rows_r;
  logic [5:0]  win_rows_r;
  logic [5:0]  win_cols_r;

  logic [NCW-1:0] nc;
  logic [15:0]    nr;
  logic [WRW-1:0] wr;
  logic [WCW-1:0] wc;

  assign nc = (num_cols_r == '0) ? NCW'(1) :
              (32'(num_cols_r) > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(num_cols_r);
  assign nr = (num_rows_r == '0) ? 16'd1 : num_rows_r;
  assign wr = (win_rows_r == '0) ? WRW'(1) :
              (32'(win_rows_r) > 32'(MAX_WIN_ROWS)) ? WRW'(MAX_WIN_ROWS) : WRW'(win_rows_r);
  assign wc = (win_cols_r == '0) ? WCW'(1) :
              (32'(win_cols_r) > 32'(MAX_WIN_COLS)) ? WCW'(MAX_WIN_COLS) : WCW'(win_cols_r);

  // Frame position and the item being worked on.
  logic [CW-1:0]         col_pos;
  logic [15:0]           row_pos;
  logic [PIXEL_BITS-1:0] pix;
  logic [CW-1:0]         c;
  logic [15:0]           r;
  logic                  last_r;
  logic [CW-1:0]         cur_c;
  logic [15:0]           cur_r;

  assign cur_c = (NCW'(col_pos) >= nc - NCW'(1)) ? CW'(nc - NCW'(1)) : col_pos;
  assign cur_r = (row_pos >= nr - 16'd1) ? (nr - 16'd1) : row_pos;

  // Row deque pointers.
  logic [RIW-1:0] rhead;
  logic [WCW-1:0] rcount;
  logic [RSW-1:0] rsum;
  logic [RSW-1:0] rsum_m1;
  logic [RIW-1:0] rpush_idx;
  logic [RIW-1:0] rback_idx;
  logic [RIW-1:0] rrd_addr;

  assign rsum      = RSW'(rhead) + RSW'(rcount);
  assign rsum_m1   = rsum - RSW'(1);
  assign rpush_idx = (rsum >= RSW'(MAX_WIN_COLS)) ? RIW'(rsum - RSW'(MAX_WIN_COLS)) : RIW'(rsum);
  assign rback_idx = (rsum_m1 >= RSW'(MAX_WIN_COLS)) ?
                     RIW'(rsum_m1 - RSW'(MAX_WIN_COLS)) : RIW'(rsum_m1);
  assign rrd_addr  = cmd.rd_row_tail ? rback_idx : rhead;

  // Column deque pointers for the current column.
  logic [CIW-1:0] chead;
  logic [WRW-1:0] ccount;
  logic [CSW-1:0] csum;
  logic [CSW-1:0] csum_m1;
  logic [CIW-1:0] cpush_idx;
  logic [CIW-1:0] cback_idx;
  logic [CIW-1:0] crd_idx;
  logic [CAW-1:0] col_base;
  logic [CAW-1:0] crd_addr;
  logic [CAW-1:0] cwr_addr;

  assign csum      = CSW'(chead) + CSW'(ccount);
  assign csum_m1   = csum - CSW'(1);
  assign cpush_idx = (csum >= CSW'(MAX_WIN_ROWS)) ? CIW'(csum - CSW'(MAX_WIN_ROWS)) : CIW'(csum);
  assign cback_idx = (csum_m1 >= CSW'(MAX_WIN_ROWS)) ?
                     CIW'(csum_m1 - CSW'(MAX_WIN_ROWS)) : CIW'(csum_m1);
  assign crd_idx   = cmd.rd_col_tail ? cback_idx : chead;
  assign col_base  = CAW'(c) * CAW'(MAX_WIN_ROWS);
  assign crd_addr  = col_base + CAW'(crd_idx);
  assign cwr_addr  = col_base + CAW'(cpush_idx);

  // Row deque store.
  logic [PIXEL_BITS-1:0] row_val_mem [MAX_WIN_COLS];
  logic [CW-1:0]         row_col_mem [MAX_WIN_COLS];
  logic [PIXEL_BITS-1:0] row_rd_val;
  logic [CW-1:0]         row_rd_col;

  always_ff @(posedge clk) begin
    if (cmd.push_row) begin
      row_val_mem[rpush_idx] <= pix;
      row_col_mem[rpush_idx] <= c;
    end
    row_rd_val <= row_val_mem[rrd_addr];
    row_rd_col <= row_col_mem[rrd_addr];
  end

  // Column deque store, one row of entries per frame column.
  logic [PIXEL_BITS-1:0] col_val_mem [MAX_COLS*MAX_WIN_ROWS];
  logic [15:0]           col_row_mem [MAX_COLS*MAX_WIN_ROWS];
  logic [PIXEL_BITS-1:0] col_rd_val;
  logic [15:0]           col_rd_row;
  logic [PIXEL_BITS-1:0] hmin;

  always_ff @(posedge clk) begin
    if (cmd.push_col) begin
      col_val_mem[cwr_addr] <= hmin;
      col_row_mem[cwr_addr] <= r;
    end
    col_rd_val <= col_val_mem[crd_addr];
    col_rd_row <= col_row_mem[crd_addr];
  end

  // Per-column head and count, tagged with the frame epoch. An entry whose
  // epoch differs from the current one stands for an empty deque.
  logic [MW-1:0] meta_mem [MAX_COLS];
  logic [MW-1:0] meta_rd;
  logic [EB-1:0] epoch;
  logic          sweep_busy;
  logic [CW-1:0] sweep_addr;

  always_ff @(posedge clk) begin
    if (sweep_busy) begin
      meta_mem[sweep_addr] <= '0;
    end else if (cmd.push_col) begin
      meta_mem[c] <= {epoch, chead, ccount + WRW'(1)};
    end
    meta_rd <= meta_mem[c];
  end

  // Result path.
  logic [PIXEL_BITS-1:0] rfront;
  logic [PIXEL_BITS-1:0] cfront;
  logic [PIXEL_BITS-1:0] wmin;
  logic [62:0]           sum_r;
  logic [63:0]           sum_add;
  logic [62:0]           sum_sat;

  assign sum_add = {1'b0, sum_r} + 64'(wmin);
  assign sum_sat = sum_add[63] ? {63{1'b1}} : sum_add[62:0];

  logic cfg_hit;
  always_comb begin
    case (swm2d_pkg::cfg_index_t'(cfg_index))
      swm2d_pkg::CFG_NUM_COLS,
      swm2d_pkg::CFG_NUM_ROWS,
      swm2d_pkg::CFG_WINDOW_ROWS,
      swm2d_pkg::CFG_WINDOW_COLS: cfg_hit = cfg_we;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  logic          restart;
  logic [EB-1:0] epoch_next;

  assign restart    = cfg_hit || (cmd.advance && last_r);
  assign epoch_next = epoch + EB'(1);

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix    <= pixel[PIXEL_BITS-1:0];
      c      <= cur_c;
      r      <= cur_r;
      last_r <= (NCW'(cur_c) == nc - NCW'(1)) && (cur_r == nr - 16'd1);
    end
    if (cmd.save_rfront) begin
      rfront <= row_rd_val;
    end
    if (cmd.push_row) begin
      hmin <= (rcount == '0) ? pix : rfront;
    end
    if (cmd.save_cfront) begin
      cfront <= col_rd_val;
    end
    if (cmd.push_col) begin
      wmin <= (ccount == '0) ? hmin : cfront;
    end
    if (cmd.emit) begin
      window_min  <= 32'(wmin);
      running_sum <= sum_sat;
      frame_done  <= last_r;
    end
    if (cmd.load_meta) begin
      if (meta_rd[MW-1 -: EB] == epoch) begin
        chead  <= meta_rd[CIW+WRW-1:WRW];
        ccount <= meta_rd[WRW-1:0];
      end else begin
        chead  <= '0;
        ccount <= '0;
      end
    end else if (cmd.pop_col_front) begin
      chead  <= (chead == CIW'(MAX_WIN_ROWS - 1)) ? '0 : chead + CIW'(1);
      ccount <= ccount - WRW'(1);
    end else if (cmd.pop_col_back) begin
      ccount <= ccount - WRW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols_r <= 11'd1024;
      num_rows_r <= 16'd1;
      win_rows_r <= 6'd1;
      win_cols_r <= 6'd1;
      col_pos    <= '0;
      row_pos    <= '0;
      rhead      <= '0;
      rcount     <= '0;
      sum_r      <= '0;
      out_valid  <= 1'b0;
      epoch      <= '0;
      sweep_busy <= 1'b1;
      sweep_addr <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        sum_r     <= sum_sat;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (sweep_busy) begin
        sweep_addr <= sweep_addr + CW'(1);
        if (sweep_addr == CW'(MAX_COLS - 1)) begin
          sweep_busy <= 1'b0;
        end
      end

      if (cmd.pop_row_front) begin
        rhead  <= (rhead == RIW'(MAX_WIN_COLS - 1)) ? '0 : rhead + RIW'(1);
        rcount <= rcount - WCW'(1);
      end else if (cmd.pop_row_back) begin
        rcount <= rcount - WCW'(1);
      end else if (cmd.push_row) begin
        rcount <= rcount + WCW'(1);
      end

      if (cmd.advance && !last_r) begin
        if (NCW'(c) == nc - NCW'(1)) begin
          col_pos <= '0;
          row_pos <= r + 16'd1;
          rhead   <= '0;
          rcount  <= '0;
        end else begin
          col_pos <= c + CW'(1);
          row_pos <= r;
        end
      end

      if (cfg_we) begin
        case (swm2d_pkg::cfg_index_t'(cfg_index))
          swm2d_pkg::CFG_NUM_COLS:    num_cols_r <= cfg_data[10:0];
          swm2d_pkg::CFG_NUM_ROWS:    num_rows_r <= cfg_data[15:0];
          swm2d_pkg::CFG_WINDOW_ROWS: win_rows_r <= cfg_data[5:0];
          swm2d_pkg::CFG_WINDOW_COLS: win_cols_r <= cfg_data[5:0];
          default: ;
        endcase
      end

      // A new frame takes a new epoch; when the epoch wraps, stale tags could
      // match again, so the column table is swept back to empty.
      if (restart) begin
        col_pos <= '0;
        row_pos <= '0;
        rhead   <= '0;
        rcount  <= '0;
        sum_r   <= '0;
        epoch   <= epoch_next;
        if (epoch_next == '0) begin
          sweep_busy <= 1'b1;
          sweep_addr <= '0;
        end
      end
    end
  end

  assign sts.sweeping      = sweep_busy;
  assign sts.rcount_zero   = (rcount == '0);
  assign sts.row_front_exp = (XW'(row_rd_col) + XW'(wc)) <= XW'(c);
  assign sts.row_back_ge   = (row_rd_val >= pix);
  assign sts.do_col        = (XW'(c) + XW'(1)) >= XW'(wc);
  assign sts.ccount_zero   = (ccount == '0);
  assign sts.col_front_exp = (YW'(col_rd_row) + YW'(wr)) <= YW'(r);
  assign sts.col_back_ge   = (col_rd_val >= hmin);
  assign sts.do_out        = (YW'(r) + YW'(1)) >= YW'(wr);
  assign sts.out_free      = !out_valid || !out_stall;

endmodule

FILE: rtl/swm2d_ctrl.sv
module swm2d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  swm2d_pkg::swm2d_sts_t sts,
  output swm2d_pkg::swm2d_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RF_RD, S_RF_CHK, S_RB_RD, S_RB_CHK, S_R_PUSH, S_M_RD, S_M_LD,
    S_CF_RD, S_CF_CHK, S_CB_RD, S_CB_CHK, S_C_PUSH, S_EMIT, S_ADV
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE) || sts.sweeping;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !sts.sweeping) begin
          cmd.load   = 1'b1;
          state_next = S_RF_RD;
        end
      end
      // Drop expired entries from the front of the row deque.
      S_RF_RD:  state_next = sts.rcount_zero ? S_R_PUSH : S_RF_CHK;
      S_RF_CHK: begin
        if (sts.row_front_exp) begin
          cmd.pop_row_front = 1'b1;
          state_next        = S_RF_RD;
        end else begin
          cmd.save_rfront = 1'b1;
          state_next      = S_RB_RD;
        end
      end
      // Drop entries not smaller than the new pixel from the back.
      S_RB_RD: begin
        cmd.rd_row_tail = 1'b1;
        state_next      = sts.rcount_zero ? S_R_PUSH : S_RB_CHK;
      end
      S_RB_CHK: begin
        if (sts.row_back_ge) begin
          cmd.pop_row_back = 1'b1;
          state_next       = S_RB_RD;
        end else begin
          state_next = S_R_PUSH;
        end
      end
      S_R_PUSH: begin
        cmd.push_row = 1'b1;
        state_next   = sts.do_col ? S_M_RD : S_ADV;
      end
      S_M_RD: state_next = S_M_LD;
      S_M_LD: begin
        cmd.load_meta = 1'b1;
        state_next    = S_CF_RD;
      end
      S_CF_RD:  state_next = sts.ccount_zero ? S_C_PUSH : S_CF_CHK;
      S_CF_CHK: begin
        if (sts.col_front_exp) begin
          cmd.pop_col_front = 1'b1;
          state_next        = S_CF_RD;
        end else begin
          cmd.save_cfront = 1'b1;
          state_next      = S_CB_RD;
        end
      end
      S_CB_RD: begin
        cmd.rd_col_tail = 1'b1;
        state_next      = sts.ccount_zero ? S_C_PUSH : S_CB_CHK;
      end
      S_CB_CHK: begin
        if (sts.col_back_ge) begin
          cmd.pop_col_back = 1'b1;
          state_next       = S_CB_RD;
        end else begin
          state_next = S_C_PUSH;
        end
      end
      S_C_PUSH: begin
        cmd.push_col = 1'b1;
        state_next   = sts.do_out ? S_EMIT : S_ADV;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/sliding_window_min_2d_sum.sv
// Works on one pixel at a time: in_stall stays high from an accepted pixel until its
// deque pop loops, each pop a read and a compare, and any output for it are done.
// Reset: synchronous; afterwards a sweep over all MAX_COLS entries empties the column table,
// and the same sweep runs every 256th frame restart. No pixel is taken during a sweep.
module sliding_window_min_2d_sum #(
  parameter int MAX_COLS     = 1024,
  parameter int MAX_WIN_ROWS = 32,
  parameter int MAX_WIN_COLS = 32,
  parameter int PIXEL_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [swm2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [swm2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [31:0]                          pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          window_min,
  output logic [62:0]                          running_sum,
  output logic                                 frame_done
);

  swm2d_pkg::swm2d_cmd_t cmd;
  swm2d_pkg::swm2d_sts_t sts;

  swm2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm2d_dp #(
    .MAX_COLS     (MAX_COLS),
    .MAX_WIN_ROWS (MAX_WIN_ROWS),
    .MAX_WIN_COLS (MAX_WIN_COLS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .window_min  (window_min),
    .running_sum (running_sum),
    .frame_done  (frame_done)
  );

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_WIN_ROWS = 32;
  localparam int MAX_WIN_COLS = 32;
  localparam int DW           = swm2d_pkg::CFG_DATA_BITS;
  localparam int DRAIN_CYCLES = 2 * (MAX_WIN_COLS + MAX_WIN_ROWS) + 40;
  localparam int STALL_LIMIT  = 20000;
  localparam int EXP_DEPTH    = 64;
  localparam logic [swm2d_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd5;
  localparam logic [63:0] SUM_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] wmin;
    logic [62:0] sum;
    logic        done;
  } window_result_t;

  logic clk, rst;
  logic cfg_we;
  logic [swm2d_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [swm2d_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] pixel, window_min;
  logic [62:0] running_sum;
  logic frame_done;

  sliding_window_min_2d_sum uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall), .window_min(window_min),
    .running_sum(running_sum), .frame_done(frame_done)
  );

  // Predictor state: raw registers, frame position and recent rows of pixels.
  logic [10:0] reg_cols;
  logic [15:0] reg_rows;
  logic [5:0]  reg_wrows, reg_wcols;
  int unsigned cur_row, cur_col;
  logic [63:0] min_sum;
  logic [31:0] line_buf [MAX_WIN_ROWS][MAX_COLS];

  // Expected results in order, kept in a ring of entries.
  window_result_t exp_mem [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int pixels_sent = 0;
  int burst_left = 0;
  int gap_max = 6;
  int stall_mode = 0;
  int stall_run = 0;
  int idle_cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void restart_frame();
    cur_row = 0;
    cur_col = 0;
    min_sum = 0;
  endfunction

  function automatic void apply_register(logic [swm2d_pkg::CFG_INDEX_BITS-1:0] idx,
                                         logic [swm2d_pkg::CFG_DATA_BITS-1:0] val);
    case (idx)
      swm2d_pkg::CFG_NUM_COLS:    reg_cols  = val[10:0];
      swm2d_pkg::CFG_NUM_ROWS:    reg_rows  = val;
      swm2d_pkg::CFG_WINDOW_ROWS: reg_wrows = val[5:0];
      swm2d_pkg::CFG_WINDOW_COLS: reg_wcols = val[5:0];
      default: return;
    endcase
    restart_frame();
  endfunction

  // Computes the window minimum and running sum ending at this pixel, if a full window ends here.
  function automatic void predict_window(logic [31:0] pix);
    int unsigned nc, nr, wr, wc, c, r;
    logic [31:0] m;
    logic last;
    window_result_t res;
    nc = eff(reg_cols, MAX_COLS);
    nr = eff(reg_rows, 65535);
    wr = eff(reg_wrows, MAX_WIN_ROWS);
    wc = eff(reg_wcols, MAX_WIN_COLS);
    c = (cur_col >= nc) ? nc - 1 : cur_col;
    r = (cur_row >= nr) ? nr - 1 : cur_row;
    last = (c == nc - 1) && (r == nr - 1);
    line_buf[r % MAX_WIN_ROWS][c] = pix;
    if (c + 1 >= wc && r + 1 >= wr) begin
      m = 32'hFFFF_FFFF;
      for (int i = r + 1 - wr; i <= r; i++)
        for (int j = c + 1 - wc; j <= c; j++)
          if (line_buf[i % MAX_WIN_ROWS][j] < m) m = line_buf[i % MAX_WIN_ROWS][j];
      if (SUM_TOP - min_sum < {32'd0, m}) min_sum = SUM_TOP;
      else min_sum = min_sum + m;
      res.wmin = m;
      res.sum = min_sum[62:0];
      res.done = last;
      exp_mem[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
    end
    if (last) begin
      restart_frame();
    end else if (c == nc - 1) begin
      cur_col = 0;
      cur_row = r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result: window_min %0h running_sum %0h frame_done %0b",
               window_min, running_sum, frame_done);
        errors++;
      end else begin
        window_result_t e;
        e = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (window_min !== e.wmin) begin
          $error("window_min: expected %0h, got %0h", e.wmin, window_min);
          errors++;
        end
        if (running_sum !== e.sum) begin
          $error("running_sum: expected %0h, got %0h", e.sum, running_sum);
          errors++;
        end
        if (frame_done !== e.done) begin
          $error("frame_done: expected %0b, got %0b", e.done, frame_done);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: off, random, or alternating runs of stall and no stall.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall <= ~out_stall;
          stall_run = out_stall ? $urandom_range(0, 12) : $urandom_range(0, 25);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pixel(logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    pixel <= v;
    do @(posedge clk); while (in_stall);
    predict_window(v);
    pixels_sent++;
  endtask

  // Lets the block finish all work so a register can be written.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    wait (exp_wr == exp_rd);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [swm2d_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [swm2d_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_register(idx, val);
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic set_frame(int nc, int nr, int wr, int wc);
    settle();
    write_reg(swm2d_pkg::CFG_NUM_COLS, DW'(nc));
    write_reg(swm2d_pkg::CFG_NUM_ROWS, DW'(nr));
    write_reg(swm2d_pkg::CFG_WINDOW_ROWS, DW'(wr));
    write_reg(swm2d_pkg::CFG_WINDOW_COLS, DW'(wc));
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    endcase
  endfunction

  task automatic test_basic_window();
    logic [31:0] vals [12] = '{32'hFFFF_FFFF, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'h7, 32'h7, 32'h7, 32'h8000_0000,
                               32'h0000_0001, 32'hFFFF_FFFE, 32'h7, 32'h3};
    set_frame(4, 3, 2, 2);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  task automatic test_zero_registers();
    set_frame(0, 0, 0, 0);
    send_pixel(32'h0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
  endtask

  task automatic test_oversize_window();
    set_frame(3, 2, 5, 4);
    repeat (6) send_pixel(rand_pixel());
    settle();
    write_reg(swm2d_pkg::CFG_WINDOW_ROWS, 16'd2);
    repeat (6) send_pixel(rand_pixel());
  endtask

  task automatic test_restart_mid_frame();
    set_frame(5, 4, 2, 3);
    repeat (7) send_pixel(rand_pixel());
    settle();
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    repeat (5) send_pixel(rand_pixel());
    settle();
    write_reg(swm2d_pkg::CFG_NUM_ROWS, 16'd3);
    repeat (15) send_pixel(rand_pixel());
  endtask

  // Values above the limits saturate: a full-width row with the widest window,
  // then the tallest window over a narrow frame, then a one-column frame of 65535 rows.
  task automatic test_register_limits();
    set_frame(16'hFFFF, 1, 1, 63);
    stall_mode = 1;
    repeat (MAX_COLS) send_pixel($urandom);
    set_frame(3, 34, 63, 2);
    stall_mode = 0;
    repeat (3 * 34) send_pixel(rand_pixel());
    set_frame(1, 16'hFFFF, 1, 1);
    repeat (10) send_pixel(rand_pixel());
  endtask

  task automatic test_random_frames();
    int nc, nr, wr, wc, frames, count;
    while (pixels_sent < 1400) begin
      nc = $urandom_range(1, 16);
      nr = $urandom_range(1, 10);
      wr = $urandom_range(0, 6);
      wc = $urandom_range(0, 6);
      stall_mode = $urandom_range(0, 2);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      set_frame(nc, nr, wr, wc);
      frames = $urandom_range(1, 2);
      count = frames * (nc == 0 ? 1 : nc) * (nr == 0 ? 1 : nr);
      // Sometimes the last frame is cut short by the next register write.
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      repeat (count) send_pixel(rand_pixel());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = swm2d_pkg::CFG_NUM_COLS;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    out_stall = 1'b0;
    reg_cols = 11'd1024;
    reg_rows = 16'd1;
    reg_wrows = 6'd1;
    reg_wcols = 6'd1;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_basic_window();
    test_zero_registers();
    test_oversize_window();
    test_restart_mid_frame();
    test_register_limits();
    test_random_frames();

    @(negedge clk) in_valid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/swm2d_pkg.sv
rtl/swm2d_dp.sv
rtl/swm2d_ctrl.sv
rtl/sliding_window_min_2d_sum.sv
tb/tb.sv
